/* design/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg: shared types, widths and helpers of the look-at view matrix block
// Fixed-point format, derived data widths, pipeline depths and the rounding
// and saturation helpers used by the arithmetic stages.
// ----------------------------------------------------------------------------
package lav_pkg;

	localparam int FRAC_BITS = 16;

	// Unit vector component: magnitude up to 1.0, plus sign.
	localparam int FW = FRAC_BITS + 2;
	// Cross product term of a unit component with a 32-bit up component.
	localparam int NW = FW + 32;
	// u = r x f after rounding.
	localparam int UW = FW + 3;
	// Wide accumulator for sums before rounding.
	localparam int XW = UW + 34;
	// Normalizing shift amount.
	localparam int SAW = $clog2(NW);

	// Square root: 32 result bits, two per stage.
	localparam int SQ_STEPS  = 2;
	localparam int SQ_STAGES = 32 / SQ_STEPS;

	// Division: FRAC_BITS + 1 quotient bits, two per stage.
	localparam int DV_BITS   = FRAC_BITS + 1;
	localparam int DV_STEPS  = 2;
	localparam int DV_STAGES = (DV_BITS + DV_STEPS - 1) / DV_STEPS;
	localparam int NUMW      = FRAC_BITS + 32;

	localparam logic [1:0] REG_UP_X = 2'd0;
	localparam logic [1:0] REG_UP_Y = 2'd1;
	localparam logic [1:0] REG_UP_Z = 2'd2;

	localparam logic [31:0] UP_Y_RESET = 32'h0001_0000;

	typedef logic [31:0]   word_t;
	typedef logic [FW-1:0] fix_t;
	typedef logic [NW-1:0] nvec_t;

	typedef struct packed {
		word_t [2:0] eye;
		fix_t  [2:0] f;
		logic        degen;
	} side_t;

	// Rows 0 to 2, four entries each; row 3 is fixed.
	typedef struct packed {
		word_t [2:0][3:0] ent;
		logic             degen;
	} mat_t;

	// Shift right by FRAC_BITS, rounding half away from zero.
	function automatic logic signed [XW-1:0] round_shift(input logic signed [XW-1:0] x);
		logic [XW-1:0] m;
		m = x[XW-1] ? (~x + XW'(1)) : x;
		m = (m + (XW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return x[XW-1] ? (~m + XW'(1)) : m;
	endfunction

	function automatic word_t sat32(input logic signed [XW-1:0] x);
		if (x[XW-1:31] == '0 || x[XW-1:31] == '1) begin
			return x[31:0];
		end
		return x[XW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

endpackage

/* design/lav_norm.sv */
// ----------------------------------------------------------------------------
// lav_norm: pipelined three-component vector normalizer
// Scales the magnitudes so the largest lies in [2^30, 2^31), takes the integer
// square root of the sum of squares and divides each component by it.
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  nvec_t [2:0] in_v,
	input  side_t       in_side,
	output logic        out_valid,
	output fix_t  [2:0] out_v,
	output logic        out_zero,
	output side_t       out_side
);

	typedef struct packed {
		side_t      side;
		logic [2:0] sgn;
		logic       zero;
	} pass_t;

	typedef struct packed {
		pass_t             ps;
		logic [2:0][30:0]  a;
		logic [63:0]       rem;
		logic [31:0]       root;
	} sq_t;

	typedef struct packed {
		pass_t                  ps;
		logic [31:0]            s;
		logic [2:0][NUMW-1:0]   num;
		logic [2:0][31:0]       rem;
		logic [2:0][DV_BITS-1:0] q;
	} dv_t;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	pass_t             ps_s1, ps_s2, ps_s3, ps_s4, ps_s5;
	logic [2:0][NW-1:0] mag_s1, mag_s2, mag_s3;
	logic [NW-1:0]     max_s2;
	logic              right_s3;
	logic [SAW-1:0]    amt_s3;
	logic [2:0][30:0]  a_s4, a_s5;
	logic [2:0][61:0]  sqr_s5;

	logic [SQ_STAGES:0] sqv_s6;
	sq_t                sqrt_s6 [SQ_STAGES+1];
	logic [DV_STAGES:0] dvv_s7;
	dv_t                div_s7 [DV_STAGES+1];

	logic [NW-1:0] max01;
	logic [SAW-1:0] msb;
	dv_t dv_init;

	always_comb begin
		max01 = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
	end

	always_comb begin
		msb = '0;
		for (int b = 0; b < NW; b++) begin
			if (max_s2[b]) begin
				msb = SAW'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s1.side <= in_side;
			ps_s1.zero <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				ps_s1.sgn[i] <= in_v[i][NW-1];
				mag_s1[i]    <= in_v[i][NW-1] ? (~in_v[i] + NW'(1)) : in_v[i];
			end

			ps_s2.side <= ps_s1.side;
			ps_s2.sgn  <= ps_s1.sgn;
			mag_s2     <= mag_s1;
			max_s2     <= (mag_s1[2] > max01) ? mag_s1[2] : max01;
			ps_s2.zero <= ((mag_s1[2] > max01) ? mag_s1[2] : max01) == '0;

			ps_s3    <= ps_s2;
			mag_s3   <= mag_s2;
			right_s3 <= msb > SAW'(30);
			amt_s3   <= (msb > SAW'(30)) ? (msb - SAW'(30)) : (SAW'(30) - msb);

			ps_s4 <= ps_s3;
			for (int i = 0; i < 3; i++) begin
				if (right_s3) begin
					a_s4[i] <= 31'(mag_s3[i] >> amt_s3);
				end else begin
					a_s4[i] <= 31'(mag_s3[i] << amt_s3);
				end
			end

			ps_s5 <= ps_s4;
			a_s5  <= a_s4;
			for (int i = 0; i < 3; i++) begin
				sqr_s5[i] <= {31'b0, a_s4[i]} * {31'b0, a_s4[i]};
			end
		end
	end

	// Entry 0 of the root chain holds the sum of squares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s6[0] <= 1'b0;
		end else if (en) begin
			sqv_s6[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqrt_s6[0].ps   <= ps_s5;
			sqrt_s6[0].a    <= a_s5;
			sqrt_s6[0].rem  <= 64'(sqr_s5[0]) + 64'(sqr_s5[1]) + 64'(sqr_s5[2]);
			sqrt_s6[0].root <= '0;
		end
	end

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		sq_t nx;

		always_comb begin
			int           i;
			logic [64:0]  trial;
			nx = sqrt_s6[k];
			for (int j = 0; j < SQ_STEPS; j++) begin
				i     = 31 - (k * SQ_STEPS + j);
				trial = (65'(nx.root) << (i + 1)) | (65'(1) << (2 * i));
				if ({1'b0, nx.rem} >= trial) begin
					nx.rem     = nx.rem - trial[63:0];
					nx.root[i] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s6[k+1] <= 1'b0;
			end else if (en) begin
				sqv_s6[k+1] <= sqv_s6[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqrt_s6[k+1] <= nx;
			end
		end
	end

	// Numerator is (a << FRAC_BITS) plus half the root; the quotient never
	// exceeds 1.0, so the top bits of the numerator start below the divisor.
	always_comb begin
		dv_init.ps = sqrt_s6[SQ_STAGES].ps;
		dv_init.s  = sqrt_s6[SQ_STAGES].root;
		dv_init.q  = '0;
		for (int i = 0; i < 3; i++) begin
			dv_init.num[i] = NUMW'({sqrt_s6[SQ_STAGES].a[i], {FRAC_BITS{1'b0}}})
				+ NUMW'(sqrt_s6[SQ_STAGES].root >> 1);
			dv_init.rem[i] = 32'(dv_init.num[i] >> (FRAC_BITS + 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv_s7[0] <= 1'b0;
		end else if (en) begin
			dvv_s7[0] <= sqv_s6[SQ_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s7[0] <= dv_init;
		end
	end

	for (genvar k = 0; k < DV_STAGES; k++) begin : g_div
		dv_t nx;

		always_comb begin
			int          b;
			logic [32:0] r33;
			nx = div_s7[k];
			for (int j = 0; j < DV_STEPS; j++) begin
				b = DV_BITS - 1 - (k * DV_STEPS + j);
				if (b >= 0) begin
					for (int i = 0; i < 3; i++) begin
						r33 = {nx.rem[i], nx.num[i][b]};
						if (r33 >= {1'b0, nx.s}) begin
							r33          = r33 - {1'b0, nx.s};
							nx.q[i][b]   = 1'b1;
						end
						nx.rem[i] = r33[31:0];
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s7[k+1] <= 1'b0;
			end else if (en) begin
				dvv_s7[k+1] <= dvv_s7[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s7[k+1] <= nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dvv_s7[DV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_zero <= div_s7[DV_STAGES].ps.zero;
			out_side <= div_s7[DV_STAGES].ps.side;
			for (int i = 0; i < 3; i++) begin
				if (div_s7[DV_STAGES].ps.sgn[i]) begin
					out_v[i] <= ~FW'(div_s7[DV_STAGES].q[i]) + FW'(1);
				end else begin
					out_v[i] <= FW'(div_s7[DV_STAGES].q[i]);
				end
			end
		end
	end

endmodule

/* design/lav_cross.sv */
// ----------------------------------------------------------------------------
// lav_cross: forward vector crossed with the world up vector
// Two stages: six signed products, then the three differences.
// ----------------------------------------------------------------------------
module lav_cross import lav_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  fix_t  [2:0] f,
	input  logic        zero,
	input  side_t       in_side,
	input  word_t [2:0] up,
	output logic        out_valid,
	output nvec_t [2:0] c,
	output side_t       out_side
);

	logic                    v_s1;
	logic signed [NW-1:0]    pa_s1 [3];
	logic signed [NW-1:0]    pb_s1 [3];
	side_t                   side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s1[i] <= $signed(f[(i + 1) % 3]) * $signed(up[(i + 2) % 3]);
				pb_s1[i] <= $signed(f[(i + 2) % 3]) * $signed(up[(i + 1) % 3]);
			end
			side_s1.eye   <= in_side.eye;
			side_s1.f     <= f;
			side_s1.degen <= zero;

			for (int i = 0; i < 3; i++) begin
				c[i] <= pa_s1[i] - pb_s1[i];
			end
			out_side <= side_s1;
		end
	end

endmodule

/* design/lav_basis.sv */
// ----------------------------------------------------------------------------
// lav_basis: up vector, translation terms and saturation of the matrix rows
// Six stages: products, sums, rounding, u-by-eye products, sum, final rows.
// ----------------------------------------------------------------------------
module lav_basis import lav_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  fix_t  [2:0] r,
	input  logic        zero,
	input  side_t       in_side,
	output logic        out_valid,
	output mat_t        out_m
);

	logic [5:0] v_q;

	logic signed [2*FW-1:0] ua_s1 [3];
	logic signed [2*FW-1:0] ub_s1 [3];
	logic signed [NW-1:0]   re_s1 [3];
	logic signed [NW-1:0]   fe_s1 [3];
	fix_t  [2:0]            r_s1, r_s2, r_s3, r_s4, r_s5;
	fix_t  [2:0]            f_s1, f_s2, f_s3, f_s4, f_s5;
	word_t [2:0]            eye_s1, eye_s2, eye_s3;
	logic                   dg_s1, dg_s2, dg_s3, dg_s4, dg_s5;

	logic signed [XW-1:0]   ux_s2 [3];
	logic signed [XW-1:0]   dr_s2, df_s2;

	logic [2:0][UW-1:0]     u_s3, u_s4, u_s5;
	word_t                  tr_s3, tr_s4, tr_s5;
	word_t                  tf_s3, tf_s4, tf_s5;

	logic signed [UW+31:0]  ue_s4 [3];
	logic signed [XW-1:0]   du_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[4:0], in_valid};
		end
	end

	assign out_valid = v_q[5];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ua_s1[i] <= $signed(r[(i + 1) % 3]) * $signed(in_side.f[(i + 2) % 3]);
				ub_s1[i] <= $signed(r[(i + 2) % 3]) * $signed(in_side.f[(i + 1) % 3]);
				re_s1[i] <= $signed(r[i]) * $signed(in_side.eye[i]);
				fe_s1[i] <= $signed(in_side.f[i]) * $signed(in_side.eye[i]);
			end
			r_s1   <= r;
			f_s1   <= in_side.f;
			eye_s1 <= in_side.eye;
			dg_s1  <= in_side.degen | zero;

			for (int i = 0; i < 3; i++) begin
				ux_s2[i] <= XW'(ua_s1[i]) - XW'(ub_s1[i]);
			end
			dr_s2  <= XW'(re_s1[0]) + XW'(re_s1[1]) + XW'(re_s1[2]);
			df_s2  <= XW'(fe_s1[0]) + XW'(fe_s1[1]) + XW'(fe_s1[2]);
			r_s2   <= r_s1;
			f_s2   <= f_s1;
			eye_s2 <= eye_s1;
			dg_s2  <= dg_s1;

			for (int i = 0; i < 3; i++) begin
				u_s3[i] <= UW'(round_shift(ux_s2[i]));
			end
			tr_s3  <= sat32(-round_shift(dr_s2));
			tf_s3  <= sat32(round_shift(df_s2));
			r_s3   <= r_s2;
			f_s3   <= f_s2;
			eye_s3 <= eye_s2;
			dg_s3  <= dg_s2;

			for (int i = 0; i < 3; i++) begin
				ue_s4[i] <= $signed(u_s3[i]) * $signed(eye_s3[i]);
			end
			u_s4  <= u_s3;
			tr_s4 <= tr_s3;
			tf_s4 <= tf_s3;
			r_s4  <= r_s3;
			f_s4  <= f_s3;
			dg_s4 <= dg_s3;

			du_s5 <= XW'(ue_s4[0]) + XW'(ue_s4[1]) + XW'(ue_s4[2]);
			u_s5  <= u_s4;
			tr_s5 <= tr_s4;
			tf_s5 <= tf_s4;
			r_s5  <= r_s4;
			f_s5  <= f_s4;
			dg_s5 <= dg_s4;

			out_m.degen <= dg_s5;
			if (dg_s5) begin
				out_m.ent <= '0;
			end else begin
				for (int i = 0; i < 3; i++) begin
					out_m.ent[0][i] <= sat32(XW'($signed(r_s5[i])));
					out_m.ent[1][i] <= sat32(XW'($signed(u_s5[i])));
					out_m.ent[2][i] <= sat32(-XW'($signed(f_s5[i])));
				end
				out_m.ent[0][3] <= tr_s5;
				out_m.ent[1][3] <= sat32(-round_shift(du_s5));
				out_m.ent[2][3] <= tf_s5;
			end
		end
	end

endmodule

/* design/lav_rowout.sv */
// ----------------------------------------------------------------------------
// lav_rowout: row serializer and output register
// Holds one finished matrix and sends its four rows as consecutive beats.
// ----------------------------------------------------------------------------
module lav_rowout import lav_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  mat_t         in_m,
	output logic         free,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,
	output logic [2:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	localparam logic [1:0] ROW_R    = 2'd0;
	localparam logic [1:0] ROW_U    = 2'd1;
	localparam logic [1:0] ROW_F    = 2'd2;
	localparam logic [1:0] ROW_LAST = 2'd3;

	logic       busy_q;
	logic [1:0] row_q;
	mat_t       mat_q;
	logic       load;
	word_t      one;

	assign free = !busy_q || (m_axis_tready && row_q == ROW_LAST);
	assign load = in_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= ROW_R;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q  <= ROW_R;
		end else if (busy_q && m_axis_tready) begin
			if (row_q == ROW_LAST) begin
				busy_q <= 1'b0;
			end
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mat_q <= in_m;
		end
	end

	assign one = mat_q.degen ? '0 : (word_t'(1) << FRAC_BITS);

	always_comb begin
		case (row_q)
			ROW_R:    m_axis_tdata = mat_q.ent[0];
			ROW_U:    m_axis_tdata = mat_q.ent[1];
			ROW_F:    m_axis_tdata = mat_q.ent[2];
			ROW_LAST: m_axis_tdata = {one, 96'b0};
			default:  m_axis_tdata = '0;
		endcase
	end

	assign m_axis_tvalid = busy_q;
	assign m_axis_tuser  = {mat_q.degen, row_q};
	assign m_axis_tlast  = row_q == ROW_LAST;

endmodule

/* design/look_at_view_matrix.sv */
// Throughput: the pipeline takes one item per cycle unless it is stalled; the
// result channel sends four rows per item, and the pipeline stalls as a whole
// while a finished matrix waits for the output serializer, so the serializer
// sets the sustained rate.
// Reset: asynchronous, active low; clears all valid bits and sets the up
// vector to (0, 1.0, 0).
// ----------------------------------------------------------------------------
// look_at_view_matrix: right-handed look-at view matrix in Q16.16
// Normalizes the direction, crosses it with the up vector, normalizes again,
// then forms u, the translation column and the four matrix rows.
// ----------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // col0, col1, col2, col3
	output logic [2:0]   m_axis_tuser,   // row_index[1:0], degenerate
	output logic         m_axis_tlast,   // last_row
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic        en;
	logic        free;
	word_t [2:0] up_q;
	nvec_t [2:0] dir_ext;
	side_t       in_side;

	logic        n1_valid, n1_zero;
	fix_t  [2:0] n1_v;
	side_t       n1_side;
	logic        cx_valid;
	nvec_t [2:0] cx_c;
	side_t       cx_side;
	logic        n2_valid, n2_zero;
	fix_t  [2:0] n2_v;
	side_t       n2_side;
	logic        bs_valid;
	mat_t        bs_m;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q[0] <= '0;
			up_q[1] <= UP_Y_RESET;
			up_q[2] <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_UP_X: up_q[0] <= cfg_data;
				REG_UP_Y: up_q[1] <= cfg_data;
				REG_UP_Z: up_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves unless a finished matrix waits for the serializer.
	assign en            = !bs_valid || free;
	assign s_axis_tready = en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir_ext[i]     = {{(NW - 32){s_axis_tdata[96 + 32*i + 31]}},
				s_axis_tdata[96 + 32*i +: 32]};
			in_side.eye[i] = s_axis_tdata[32*i +: 32];
		end
		in_side.f     = '0;
		in_side.degen = 1'b0;
	end

	lav_norm u_norm_f (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.in_v      (dir_ext),
		.in_side   (in_side),
		.out_valid (n1_valid),
		.out_v     (n1_v),
		.out_zero  (n1_zero),
		.out_side  (n1_side)
	);

	lav_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (n1_valid),
		.f         (n1_v),
		.zero      (n1_zero),
		.in_side   (n1_side),
		.up        (up_q),
		.out_valid (cx_valid),
		.c         (cx_c),
		.out_side  (cx_side)
	);

	lav_norm u_norm_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cx_valid),
		.in_v      (cx_c),
		.in_side   (cx_side),
		.out_valid (n2_valid),
		.out_v     (n2_v),
		.out_zero  (n2_zero),
		.out_side  (n2_side)
	);

	lav_basis u_basis (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (n2_valid),
		.r         (n2_v),
		.zero      (n2_zero),
		.in_side   (n2_side),
		.out_valid (bs_valid),
		.out_m     (bs_m)
	);

	lav_rowout u_rowout (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (bs_valid && en),
		.in_m          (bs_m),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
